FILE: hdl/ctg_pkg.sv
package ctg_pkg;

    localparam int POS_W     = 4;
    localparam int N_W       = 5;
    localparam int R_W       = 4;
    localparam int MODE_W    = 2;
    localparam int PACK_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // tuple positions are 4 bits wide and at most eight of them fit in the packed word
    localparam int POS_LIMIT  = 16;
    localparam int PICK_LIMIT = 8;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int MAX_PICK_DEF  = 8;

    localparam logic [N_W-1:0] ITEM_COUNT_RST = 5'd4;
    localparam logic [R_W-1:0] PICK_COUNT_RST = 4'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd2;

    localparam logic [MODE_W-1:0] MODE_COMB = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MSET = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REP  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INIT,
        OP_START,
        OP_STEP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [MODE_W-1:0] mode;
        logic [N_W-1:0]    n;
        logic [R_W-1:0]    r;
    } ctrl_t;

    typedef struct packed {
        logic             above_found;
        logic [POS_W-1:0] above_val;
        logic [POS_W-1:0] low_val;
    } mask_info_t;

    typedef struct packed {
        logic scan_tok;
        logic fill_tok;
        logic last_ok;
    } cell_stat_t;

endpackage

FILE: hdl/combinatorial_tuple_generator_core.sv
// Lexicographic tuple generator: combinations, permutations, multiset
// combinations and base-n counting over items 0..n-1, tuple length r.
// Registers item_count, pick_count and mode are set through write_en,
// write_index and write_data; the user is to set them only while the block
// is idle, which the block itself does not enforce. A write to any of the
// three ends the enumeration under way, so the next request gives the first
// tuple. Input channel (in_valid, in_stall, restart): restart = 1 asks for
// the first tuple, 0 for the next one. Every request gives exactly one
// result on the output channel (out_valid, out_stall, tuple_packed,
// final_tuple, exhausted), held in an output register until taken.
// A restart, or a request after the last tuple, goes from accept straight
// to the hold state. A next request walks the scan token left from the
// rightmost active cell one cell per cycle until a position can advance,
// and the refill walks back right one cell per cycle. When no position can
// advance the scan runs off the left end and the result is exhausted.
// One request is in work at a time; in_stall is high from accept until its
// result is loaded into the output register, and the next item can be taken
// in the cycle after, so a stalled receiver holds off at most one further
// request. Reset sets n = 4, r = 2, mode = combinations and no enumeration
// started.
module combinatorial_tuple_generator_core #(
    parameter int MAX_ITEMS = ctg_pkg::MAX_ITEMS_DEF,
    parameter int MAX_PICK  = ctg_pkg::MAX_PICK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_en,
    input  logic [ctg_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [ctg_pkg::CFG_W-1:0]     write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ctg_pkg::PACK_W-1:0]    tuple_packed,
    output logic                          final_tuple,
    output logic                          exhausted
);

    localparam int MASK_W    = (MAX_ITEMS < ctg_pkg::POS_LIMIT) ? MAX_ITEMS : ctg_pkg::POS_LIMIT;
    localparam int NUM_CELLS = (MAX_PICK < ctg_pkg::PICK_LIMIT) ? MAX_PICK : ctg_pkg::PICK_LIMIT;

    logic [ctg_pkg::N_W-1:0]    item_count_reg;
    logic [ctg_pkg::R_W-1:0]    pick_count_reg;
    logic [ctg_pkg::MODE_W-1:0] mode_reg;

    ctg_pkg::state_t state_reg;
    ctg_pkg::state_t state_next;
    logic            started_reg;
    logic            started_next;
    logic            finished_reg;
    logic            finished_next;
    logic            ok_reg;
    logic            ok_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ctg_pkg::PACK_W-1:0] packed_reg;
    logic                       final_reg;
    logic                       exhausted_reg;

    logic [ctg_pkg::N_W-1:0] n_eff;
    logic [ctg_pkg::R_W-1:0] r_eff;
    logic                    first_ok;
    logic                    load_out;
    logic                    any_tok;
    logic                    last_all;
    logic [ctg_pkg::PACK_W-1:0] packed_comb;
    logic [ctg_pkg::POS_W-1:0]  scan_pos;

    ctg_pkg::ctrl_t      ctrl;
    ctg_pkg::mask_info_t mask_info;
    ctg_pkg::op_t        op;

    logic [ctg_pkg::POS_W-1:0] pos_arr [NUM_CELLS];
    ctg_pkg::cell_stat_t       stat_arr [NUM_CELLS];
    logic [NUM_CELLS-1:0]      scan_out_vec;
    logic [NUM_CELLS-1:0]      fill_out_vec;
    logic [NUM_CELLS-1:0]      scan_tok_vec;
    logic [NUM_CELLS-1:0]      fill_tok_vec;
    logic [NUM_CELLS-1:0]      last_vec;

    assign n_eff = (item_count_reg > ctg_pkg::N_W'(MASK_W)) ?
                   ctg_pkg::N_W'(MASK_W) : item_count_reg;
    assign r_eff = (pick_count_reg > ctg_pkg::R_W'(NUM_CELLS)) ?
                   ctg_pkg::R_W'(NUM_CELLS) : pick_count_reg;

    always_comb
    begin
        if (mode_reg == ctg_pkg::MODE_COMB || mode_reg == ctg_pkg::MODE_PERM)
        begin
            first_ok = {1'b0, r_eff} <= n_eff;
        end
        else
        begin
            first_ok = !(r_eff != '0 && n_eff == '0);
        end
    end

    assign ctrl.op   = op;
    assign ctrl.mode = mode_reg;
    assign ctrl.n    = n_eff;
    assign ctrl.r    = r_eff;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [ctg_pkg::POS_W-1:0] left_pos;
        logic                      scan_in;
        logic                      fill_in;

        if (i == 0)
        begin : g_first
            assign left_pos = '0;
            assign fill_in  = 1'b0;
        end
        else
        begin : g_rest
            assign left_pos = pos_arr[i-1];
            assign fill_in  = fill_out_vec[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_last
            assign scan_in = 1'b0;
        end
        else
        begin : g_inner
            assign scan_in = scan_out_vec[i+1];
        end

        ctg_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .mask_info (mask_info),
            .left_pos  (left_pos),
            .scan_in   (scan_in),
            .fill_in   (fill_in),
            .pos       (pos_arr[i]),
            .stat      (stat_arr[i]),
            .scan_out  (scan_out_vec[i]),
            .fill_out  (fill_out_vec[i])
        );

        assign scan_tok_vec[i] = stat_arr[i].scan_tok;
        assign fill_tok_vec[i] = stat_arr[i].fill_tok;
        assign last_vec[i]     = stat_arr[i].last_ok;
    end

    assign any_tok  = |{scan_tok_vec, fill_tok_vec};
    assign last_all = &last_vec;

    always_comb
    begin
        scan_pos    = '0;
        packed_comb = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            scan_pos = scan_pos | (pos_arr[i] & {ctg_pkg::POS_W{scan_tok_vec[i]}});
            if (ctg_pkg::R_W'(i) < r_eff)
            begin
                packed_comb[ctg_pkg::POS_W*i +: ctg_pkg::POS_W] = pos_arr[i];
            end
        end
    end

    ctg_mask #(
        .MASK_W (MASK_W)
    ) u_mask (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .scan_act (|scan_tok_vec),
        .fill_act (|fill_tok_vec),
        .scan_pos (scan_pos),
        .info     (mask_info)
    );

    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        ok_next       = ok_reg;
        op            = ctg_pkg::OP_HOLD;
        load_out      = 1'b0;
        case (state_reg)
            ctg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart || !started_reg)
                    begin
                        op            = ctg_pkg::OP_INIT;
                        started_next  = 1'b1;
                        finished_next = 1'b0;
                        ok_next       = first_ok;
                        state_next    = ctg_pkg::ST_HOLD;
                    end
                    else if (finished_reg)
                    begin
                        ok_next    = 1'b0;
                        state_next = ctg_pkg::ST_HOLD;
                    end
                    else
                    begin
                        op         = ctg_pkg::OP_START;
                        ok_next    = 1'b1;
                        state_next = ctg_pkg::ST_WALK;
                    end
                end
            end
            ctg_pkg::ST_WALK:
            begin
                if (any_tok)
                begin
                    op = ctg_pkg::OP_STEP;
                    // scan fell off the left end: nothing can advance
                    if (scan_out_vec[0])
                    begin
                        ok_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ctg_pkg::ST_HOLD;
                end
            end
            ctg_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out      = 1'b1;
                    finished_next = !ok_reg || last_all;
                    state_next    = ctg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctg_pkg::ST_IDLE;
            end
        endcase
        if (write_en && write_index <= ctg_pkg::REG_MODE)
        begin
            started_next  = 1'b0;
            finished_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= ctg_pkg::ITEM_COUNT_RST;
            pick_count_reg <= ctg_pkg::PICK_COUNT_RST;
            mode_reg       <= ctg_pkg::MODE_COMB;
        end
        else if (write_en)
        begin
            case (write_index)
                ctg_pkg::REG_ITEM_COUNT: item_count_reg <= write_data;
                ctg_pkg::REG_PICK_COUNT: pick_count_reg <= write_data[ctg_pkg::R_W-1:0];
                ctg_pkg::REG_MODE:       mode_reg       <= write_data[ctg_pkg::MODE_W-1:0];
                default:                 mode_reg       <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctg_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            packed_reg    <= ok_reg ? packed_comb : '0;
            final_reg     <= ok_reg && last_all;
            exhausted_reg <= !ok_reg;
        end
    end

    assign in_stall     = state_reg != ctg_pkg::ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign tuple_packed = packed_reg;
    assign final_tuple  = final_reg;
    assign exhausted    = exhausted_reg;

`ifndef NO_ASSERTIONS
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({scan_tok_vec, fill_tok_vec}))
        else $error("more than one cell holds a token");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctg_pkg::ST_IDLE) |-> !any_tok)
        else $error("token left in the chain while idle");

    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ctg_pkg::ST_HOLD))
        else $error("result appeared without a finished item");

    a_exhausted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && exhausted) |-> (tuple_packed == '0 && !final_tuple))
        else $error("exhausted result carries a tuple");
`endif

endmodule

FILE: hdl/ctg_cell.sv
module ctg_cell #(
    parameter int INDEX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ctg_pkg::ctrl_t                  ctrl,
    input  ctg_pkg::mask_info_t             mask_info,
    input  logic [ctg_pkg::POS_W-1:0]       left_pos,
    input  logic                            scan_in,
    input  logic                            fill_in,
    output logic [ctg_pkg::POS_W-1:0]       pos,
    output ctg_pkg::cell_stat_t             stat,
    output logic                            scan_out,
    output logic                            fill_out
);

    localparam logic [ctg_pkg::POS_W-1:0] IDX  = ctg_pkg::POS_W'(INDEX);
    localparam logic [5:0]                IDX6 = 6'(INDEX);

    logic [ctg_pkg::POS_W-1:0] pos_reg;
    logic [ctg_pkg::POS_W-1:0] pos_next;
    logic                      scan_tok_reg;
    logic                      scan_tok_next;
    logic                      fill_tok_reg;
    logic                      fill_tok_next;

    logic       active;
    logic       inject;
    logic       step;
    logic       can_adv;
    logic       match;
    logic [5:0] pos6;
    logic [5:0] r6;
    logic [5:0] n6;
    logic [ctg_pkg::POS_W-1:0] fill_val;

    assign pos6   = {2'b00, pos_reg};
    assign r6     = {2'b00, ctrl.r};
    assign n6     = {1'b0, ctrl.n};
    assign active = IDX < ctrl.r;
    assign step   = (ctrl.op == ctg_pkg::OP_START) || (ctrl.op == ctg_pkg::OP_STEP);
    // scan starts at the rightmost active cell
    assign inject = (ctrl.op == ctg_pkg::OP_START) && ({1'b0, IDX} + 5'd1 == {1'b0, ctrl.r});

    always_comb
    begin
        case (ctrl.mode)
            ctg_pkg::MODE_COMB:
            begin
                can_adv  = pos6 + r6 < n6 + IDX6;
                match    = pos6 + r6 == n6 + IDX6;
                fill_val = left_pos + 4'd1;
            end
            ctg_pkg::MODE_PERM:
            begin
                can_adv  = mask_info.above_found;
                match    = pos6 + IDX6 + 6'd1 == n6;
                fill_val = mask_info.low_val;
            end
            ctg_pkg::MODE_MSET:
            begin
                can_adv  = pos6 + 6'd1 < n6;
                match    = pos6 + 6'd1 == n6;
                fill_val = left_pos;
            end
            ctg_pkg::MODE_REP:
            begin
                can_adv  = pos6 + 6'd1 < n6;
                match    = pos6 + 6'd1 == n6;
                fill_val = '0;
            end
            default:
            begin
                can_adv  = 1'b0;
                match    = 1'b0;
                fill_val = '0;
            end
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        scan_tok_next = scan_tok_reg;
        fill_tok_next = fill_tok_reg;
        case (ctrl.op)
            ctg_pkg::OP_INIT:
            begin
                if (active && (ctrl.mode == ctg_pkg::MODE_COMB ||
                               ctrl.mode == ctg_pkg::MODE_PERM))
                begin
                    pos_next = IDX;
                end
                else
                begin
                    pos_next = '0;
                end
                scan_tok_next = 1'b0;
                fill_tok_next = 1'b0;
            end
            ctg_pkg::OP_START, ctg_pkg::OP_STEP:
            begin
                if (scan_tok_reg && can_adv)
                begin
                    pos_next = (ctrl.mode == ctg_pkg::MODE_PERM) ?
                               mask_info.above_val : pos_reg + 4'd1;
                end
                else if (fill_tok_reg)
                begin
                    pos_next = fill_val;
                end
                scan_tok_next = (scan_in || inject) && active;
                fill_tok_next = fill_in && active;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_tok_reg <= 1'b0;
            fill_tok_reg <= 1'b0;
        end
        else
        begin
            scan_tok_reg <= scan_tok_next;
            fill_tok_reg <= fill_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    // no advance here: hand the scan to the left; advance: refill to the right
    assign scan_out      = step && scan_tok_reg && !can_adv;
    assign fill_out      = step && ((scan_tok_reg && can_adv) || fill_tok_reg);
    assign pos           = pos_reg;
    assign stat.scan_tok = scan_tok_reg;
    assign stat.fill_tok = fill_tok_reg;
    assign stat.last_ok  = !active || match;

endmodule

FILE: hdl/ctg_mask.sv
module ctg_mask #(
    parameter int MASK_W = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctg_pkg::ctrl_t            ctrl,
    input  logic                      scan_act,
    input  logic                      fill_act,
    input  logic [ctg_pkg::POS_W-1:0] scan_pos,
    output ctg_pkg::mask_info_t       info
);

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [MASK_W-1:0] excl;
    logic              perm;
    logic              step;

    assign perm = ctrl.mode == ctg_pkg::MODE_PERM;
    assign step = (ctrl.op == ctg_pkg::OP_START) || (ctrl.op == ctg_pkg::OP_STEP);

    // the scanned item is released before looking for a larger free one
    always_comb
    begin
        for (int b = 0; b < MASK_W; b++)
        begin
            excl[b] = mask_reg[b] && (5'(b) != {1'b0, scan_pos});
        end
    end

    always_comb
    begin
        info.above_found = 1'b0;
        info.above_val   = '0;
        info.low_val     = '0;
        for (int b = MASK_W - 1; b >= 0; b--)
        begin
            if (5'(b) > {1'b0, scan_pos} && 5'(b) < ctrl.n && !excl[b])
            begin
                info.above_found = 1'b1;
                info.above_val   = ctg_pkg::POS_W'(b);
            end
            if (5'(b) < ctrl.n && !mask_reg[b])
            begin
                info.low_val = ctg_pkg::POS_W'(b);
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (ctrl.op == ctg_pkg::OP_INIT)
        begin
            for (int b = 0; b < MASK_W; b++)
            begin
                mask_next[b] = perm && (5'(b) < {1'b0, ctrl.r});
            end
        end
        else if (step && perm && scan_act)
        begin
            for (int b = 0; b < MASK_W; b++)
            begin
                mask_next[b] = excl[b] ||
                               (info.above_found && 5'(b) == {1'b0, info.above_val});
            end
        end
        else if (step && perm && fill_act)
        begin
            for (int b = 0; b < MASK_W; b++)
            begin
                mask_next[b] = mask_reg[b] || (5'(b) == {1'b0, info.low_val});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

endmodule

FILE: tb/combinatorial_tuple_generator_core_tb.sv
module combinatorial_tuple_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // index past the last register, a write there is dropped
    localparam logic [ctg_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [ctg_pkg::PACK_W-1:0] word;
        logic                       last;
        logic                       none;
    } tuple_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          write_en = 1'b0;
    logic [ctg_pkg::CFG_IDX_W-1:0] write_index = '0;
    logic [ctg_pkg::CFG_W-1:0]     write_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          restart = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [ctg_pkg::PACK_W-1:0]    tuple_packed;
    logic                          final_tuple;
    logic                          exhausted;

    // predictor copy of registers and enumeration state
    logic [ctg_pkg::N_W-1:0]    cfg_items = ctg_pkg::ITEM_COUNT_RST;
    logic [ctg_pkg::R_W-1:0]    cfg_picks = ctg_pkg::PICK_COUNT_RST;
    logic [ctg_pkg::MODE_W-1:0] cfg_mode = ctg_pkg::MODE_COMB;
    logic [ctg_pkg::POS_W-1:0]  tup_pos [ctg_pkg::PICK_LIMIT];
    logic [15:0]                held_mask = '0;
    bit                         walk_started = 1'b0;
    bit                         walk_done = 1'b0;

    bit            request_queue [$];
    tuple_result_t tuple_queue [$];
    int            items_sent = 0;
    int            fail_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;
    int            holds_served = 0;
    int            hold_left = 0;

    combinatorial_tuple_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tuple_packed (tuple_packed),
        .final_tuple  (final_tuple),
        .exhausted    (exhausted)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int item_span();
        int n;
        n = cfg_items;
        if (n > ctg_pkg::MAX_ITEMS_DEF) n = ctg_pkg::MAX_ITEMS_DEF;
        if (n > ctg_pkg::POS_LIMIT) n = ctg_pkg::POS_LIMIT;
        return n;
    endfunction

    function automatic int pick_span();
        int r;
        r = cfg_picks;
        if (r > ctg_pkg::MAX_PICK_DEF) r = ctg_pkg::MAX_PICK_DEF;
        if (r > ctg_pkg::PICK_LIMIT) r = ctg_pkg::PICK_LIMIT;
        return r;
    endfunction

    function automatic void note_reg_write(logic [ctg_pkg::CFG_IDX_W-1:0] idx,
                                           logic [ctg_pkg::CFG_W-1:0] val);
        case (idx)
            ctg_pkg::REG_ITEM_COUNT: cfg_items = val[ctg_pkg::N_W-1:0];
            ctg_pkg::REG_PICK_COUNT: cfg_picks = val[ctg_pkg::R_W-1:0];
            ctg_pkg::REG_MODE:       cfg_mode = val[ctg_pkg::MODE_W-1:0];
            default:                 return;
        endcase
        walk_started = 1'b0;
        walk_done = 1'b0;
    endfunction

    function automatic bit load_first();
        int n;
        int r;
        n = item_span();
        r = pick_span();
        held_mask = '0;
        for (int i = 0; i < ctg_pkg::PICK_LIMIT; i++)
            tup_pos[i] = '0;
        if ((cfg_mode == ctg_pkg::MODE_COMB || cfg_mode == ctg_pkg::MODE_PERM) && r > n)
            return 1'b0;
        if ((cfg_mode == ctg_pkg::MODE_MSET || cfg_mode == ctg_pkg::MODE_REP)
            && r > 0 && n == 0)
            return 1'b0;
        if (cfg_mode == ctg_pkg::MODE_COMB || cfg_mode == ctg_pkg::MODE_PERM)
        begin
            for (int i = 0; i < r; i++)
            begin
                tup_pos[i] = ctg_pkg::POS_W'(i);
                if (cfg_mode == ctg_pkg::MODE_PERM) held_mask[i] = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit at_final_tuple();
        int n;
        int r;
        int want;
        n = item_span();
        r = pick_span();
        for (int i = 0; i < r; i++)
        begin
            if (cfg_mode == ctg_pkg::MODE_COMB) want = n - r + i;
            else if (cfg_mode == ctg_pkg::MODE_PERM) want = n - 1 - i;
            else want = n - 1;
            if (int'(tup_pos[i]) != want) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit advance_tuple();
        int n;
        int r;
        int v;
        int lim;
        n = item_span();
        r = pick_span();
        if (cfg_mode == ctg_pkg::MODE_PERM)
        begin
            for (int i = r - 1; i >= 0; i--)
            begin
                held_mask[tup_pos[i]] = 1'b0;
                v = int'(tup_pos[i]) + 1;
                while (v < n && held_mask[v]) v++;
                if (v < n)
                begin
                    tup_pos[i] = ctg_pkg::POS_W'(v);
                    held_mask[v] = 1'b1;
                    v = 0;
                    // refill the tail with the lowest free items
                    for (int j = i + 1; j < r; j++)
                    begin
                        while (v < n && held_mask[v]) v++;
                        if (v >= n) return 1'b0;
                        tup_pos[j] = ctg_pkg::POS_W'(v);
                        held_mask[v] = 1'b1;
                    end
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        for (int i = r - 1; i >= 0; i--)
        begin
            lim = (cfg_mode == ctg_pkg::MODE_COMB) ? (n - r + i) : (n - 1);
            if (int'(tup_pos[i]) < lim)
            begin
                tup_pos[i] = tup_pos[i] + 1'b1;
                for (int j = i + 1; j < r; j++)
                begin
                    if (cfg_mode == ctg_pkg::MODE_COMB) tup_pos[j] = tup_pos[j - 1] + 1'b1;
                    else if (cfg_mode == ctg_pkg::MODE_MSET) tup_pos[j] = tup_pos[i];
                    else tup_pos[j] = '0;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_tuple(bit from_start);
        bit            ok;
        bit            last;
        int            r;
        tuple_result_t res;
        r = pick_span();
        res = '0;
        if (from_start || !walk_started)
        begin
            walk_started = 1'b1;
            walk_done = 1'b0;
            ok = load_first();
        end
        else if (walk_done)
            ok = 1'b0;
        else
            ok = advance_tuple();
        if (!ok)
        begin
            walk_done = 1'b1;
            res.none = 1'b1;
        end
        else
        begin
            last = at_final_tuple();
            if (last) walk_done = 1'b1;
            for (int i = 0; i < r; i++)
                res.word[4*i +: 4] = tup_pos[i];
            res.last = last;
        end
        tuple_queue.insert(tuple_queue.size(), res);
    endfunction

    always @(posedge clk)
    begin : request_driver
        logic taken;
        logic load;
        taken = in_valid && !in_stall;
        if (rst_n)
        begin
            if (taken) predict_tuple(restart);
            load = (!in_valid || taken) && request_queue.size() > 0
                   && ($urandom_range(99) >= send_idle_pct);
            if (load)
            begin
                in_valid <= 1'b1;
                restart <= request_queue.pop_front();
            end
            else if (taken)
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_receiver
        logic stall_now;
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            stall_now = 1'b1;
        end
        else
            stall_now = rst_n && ($urandom_range(99) < recv_stall_pct);
        out_stall <= stall_now;
    end

    always @(posedge clk)
    begin : result_checker
        tuple_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tuple_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result at %0t: tuple %h final %b exhausted %b",
                             $realtime, tuple_packed, final_tuple, exhausted);
            end
            else
            begin
                want = tuple_queue.pop_front();
                if (tuple_packed !== want.word || final_tuple !== want.last
                    || exhausted !== want.none)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at %0t: expected tuple %h final %b exhausted %b",
                                 $realtime, want.word, want.last, want.none,
                                 ", got tuple %h final %b exhausted %b",
                                 tuple_packed, final_tuple, exhausted);
                end
            end
        end
    end

    task automatic write_reg(logic [ctg_pkg::CFG_IDX_W-1:0] idx,
                             logic [ctg_pkg::CFG_W-1:0] val);
        @(posedge clk);
        write_en <= 1'b1;
        write_index <= idx;
        write_data <= val;
        note_reg_write(idx, val);
        @(posedge clk);
        write_en <= 1'b0;
    endtask

    task automatic set_regs(logic [ctg_pkg::CFG_W-1:0] n, logic [ctg_pkg::CFG_W-1:0] r,
                            logic [ctg_pkg::CFG_W-1:0] m);
        write_reg(ctg_pkg::REG_ITEM_COUNT, n);
        write_reg(ctg_pkg::REG_PICK_COUNT, r);
        write_reg(ctg_pkg::REG_MODE, m);
    endtask

    task automatic queue_request(bit from_start);
        request_queue.insert(request_queue.size(), from_start);
        items_sent++;
    endtask

    // sender stays quiet until every result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || tuple_queue.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                        idle_by_phase [4];
        int                        stall_by_phase [4];
        int                        batch;
        int                        len;
        int                        c;
        logic [ctg_pkg::CFG_W-1:0] n;
        logic [ctg_pkg::CFG_W-1:0] r;
        logic [ctg_pkg::CFG_W-1:0] m;

        idle_by_phase = '{0, 74, 0, 13};
        stall_by_phase = '{0, 0, 74, 13};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, next before any restart, run past the end
        repeat (7) queue_request(1'b0);
        wait_idle();
        set_regs(5'd2, 5'd2, ctg_pkg::CFG_W'(ctg_pkg::MODE_PERM));
        queue_request(1'b1);
        repeat (2) queue_request(1'b0);
        wait_idle();
        set_regs(5'd2, 5'd2, ctg_pkg::CFG_W'(ctg_pkg::MODE_MSET));
        queue_request(1'b1);
        repeat (3) queue_request(1'b0);
        wait_idle();
        set_regs(5'd2, 5'd1, ctg_pkg::CFG_W'(ctg_pkg::MODE_REP));
        queue_request(1'b1);
        repeat (2) queue_request(1'b0);
        wait_idle();
        // more picks than items
        set_regs(5'd2, 5'd3, ctg_pkg::CFG_W'(ctg_pkg::MODE_COMB));
        queue_request(1'b1);
        wait_idle();
        set_regs(5'd0, 5'd1, ctg_pkg::CFG_W'(ctg_pkg::MODE_REP));
        queue_request(1'b0);
        wait_idle();
        // empty tuple
        set_regs(5'd5, 5'd0, ctg_pkg::CFG_W'(ctg_pkg::MODE_PERM));
        queue_request(1'b1);
        queue_request(1'b0);
        wait_idle();
        // oversized counts get clamped
        set_regs(5'd31, 5'd15, ctg_pkg::CFG_W'(ctg_pkg::MODE_COMB));
        queue_request(1'b1);
        queue_request(1'b0);
        wait_idle();
        // dropped write leaves the enumeration running
        write_reg(REG_NONE, 5'h1f);
        queue_request(1'b0);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            batch = 0;
            while (items_sent < 25 + (phase + 1) * 382)
            begin
                if (batch > 0 && $urandom_range(99) < 10)
                    write_reg(REG_NONE, ctg_pkg::CFG_W'($urandom));
                else
                begin
                    c = $urandom_range(99);
                    m = ctg_pkg::CFG_W'($urandom_range(3));
                    if (c < 70)
                    begin
                        n = ctg_pkg::CFG_W'($urandom_range(1, 6));
                        r = ctg_pkg::CFG_W'($urandom_range(1, 4));
                    end
                    else if (c < 85)
                    begin
                        n = ctg_pkg::CFG_W'($urandom_range(7, 16));
                        r = ctg_pkg::CFG_W'($urandom_range(1, 2));
                    end
                    else if (c < 93)
                    begin
                        n = 5'd16;
                        r = 5'd8;
                    end
                    else
                    begin
                        n = ctg_pkg::CFG_W'($urandom_range(31));
                        r = ctg_pkg::CFG_W'($urandom_range(15));
                    end
                    set_regs(n, r, m);
                end
                len = (batch == 0) ? 40 : $urandom_range(4, 40);
                for (int k = 0; k < len; k++)
                    queue_request((k == 0) ? ($urandom_range(99) < 80)
                                           : ($urandom_range(99) < 6));
                // receiver sits on its input while the sender keeps offering
                if (batch == 0 && (phase == 0 || phase == 3))
                    hold_requests++;
                wait_idle();
                batch++;
            end
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ctg_pkg.sv
hdl/ctg_cell.sv
hdl/ctg_mask.sv
hdl/combinatorial_tuple_generator_core.sv
tb/combinatorial_tuple_generator_core_tb.sv
